### design/light_sensor_filter_hysteresis_defines.svh
// Assertion shorthands used by the checker file.
`ifndef LIGHT_SENSOR_FILTER_HYSTERESIS_DEFINES_SVH
`define LIGHT_SENSOR_FILTER_HYSTERESIS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSFH_ASSERT_NOW(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("lsfh: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define LSFH_ASSERT_NEXT(label, ck, rn, ante, cons) \
  label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("lsfh: next-cycle check failed");

`endif

### design/lsfh_pkg.sv
`timescale 1ns / 1ps

package lsfh_pkg;

  localparam int SAMPLE_W       = 12;
  localparam int SAMPLE_MAX_INT = 4095;
  localparam logic [SAMPLE_W-1:0] SAT_LOW  = 12'd5;
  localparam logic [SAMPLE_W-1:0] SAT_HIGH = 12'd4090;

  // Q15 exponential average
  localparam int Q15_SHIFT   = 15;
  localparam int EMA_W       = SAMPLE_W + Q15_SHIFT;  // 27
  localparam int DIFF_W      = EMA_W + 1;             // signed sample - accum
  localparam int ALPHA_W     = 16;
  localparam int ALPHA_IDX_W = 4;
  localparam int PROD_W      = DIFF_W + ALPHA_W;      // 44

  // alpha = k * 32768 / 1000 = (k << 12) / 125
  localparam int PERMILLE_W        = 10;
  localparam logic [PERMILLE_W-1:0] PERMILLE_FULL = 10'd1000;
  localparam int ALPHA_SCALE_SHIFT = 12;
  localparam int ALPHA_DIVD_W      = PERMILLE_W + ALPHA_SCALE_SHIFT;  // 22
  localparam logic [7:0] ALPHA_DIVISOR = 8'd125;
  localparam int ALPHA_REM_W       = 7;
  localparam int ALPHA_CNT_W       = 5;

  localparam int WIN_SET_W = 8;

  // ports
  localparam int CFG_ADDR_W  = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 32;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_FILTER_MODE  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ON_THRESHOLD = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_HYSTERESIS   = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_EMA_PERMILLE = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW       = 3'd4;

  // register reset values
  localparam logic [SAMPLE_W-1:0]   RST_ON_THRESHOLD = 12'd3800;
  localparam logic [SAMPLE_W-1:0]   RST_HYSTERESIS   = 12'd120;
  localparam logic [PERMILLE_W-1:0] RST_EMA_PERMILLE = 10'd250;
  localparam logic [WIN_SET_W-1:0]  RST_WINDOW       = 8'd8;

  // out_tdata flag bit positions
  localparam int OUT_LEVEL_BIT = 24;
  localparam int OUT_RISE_BIT  = 25;
  localparam int OUT_FALL_BIT  = 26;
  localparam int OUT_SAT_BIT   = 27;

  typedef struct packed {
    logic                busy;
    logic [ALPHA_W-1:0]  alpha;
  } alpha_stat_t;

endpackage

### design/light_sensor_filter_hysteresis.sv
`timescale 1ns / 1ps
// Flow, input accept to result: exponential mode loads an empty accumulator directly,
// else runs 16 serial multiply steps over the alpha bits and then updates the accumulator;
// moving-average mode reads the ring, then runs the serial restoring divide. One item in
// flight: the next item is accepted only after the result is registered and the block is
// back in idle, so a stalled output holds off the input. Synchronous active-low reset; input
// ready stays low after reset and after every write to a defined register while alpha is recomputed.
module light_sensor_filter_hysteresis #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [lsfh_pkg::IN_TDATA_W-1:0]      in_tdata,   // [11:0] sample
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [11:0] raw_out, [23:12] filtered_out, [24] level, [25] rising_edge,
  // [26] falling_edge, [27] saturated
  output logic [lsfh_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lsfh_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [lsfh_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int PTR_W   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FILL_W  = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W   = $clog2(WINDOW_MAX * lsfh_pkg::SAMPLE_MAX_INT + 1);
  localparam int STEPS   = (SUM_W > lsfh_pkg::ALPHA_W) ? SUM_W : lsfh_pkg::ALPHA_W;
  localparam int STEP_W  = $clog2(STEPS);
  localparam int SW      = lsfh_pkg::SAMPLE_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_EMA_MUL = 3'd1;
  localparam logic [2:0] ST_EMA_UPD = 3'd2;
  localparam logic [2:0] ST_SMA_RD  = 3'd3;
  localparam logic [2:0] ST_SMA_DIV = 3'd4;
  localparam logic [2:0] ST_DONE    = 3'd5;

  logic [2:0]                            state_r, state_nxt;
  logic                                  init_r;

  logic                                  mode_r, mode_nxt;
  logic [SW-1:0]                         thr_r, thr_nxt;
  logic [SW-1:0]                         hyst_r, hyst_nxt;
  logic [lsfh_pkg::PERMILLE_W-1:0]       perm_r, perm_nxt;
  logic [lsfh_pkg::WIN_SET_W-1:0]        win_r, win_nxt;

  logic [lsfh_pkg::EMA_W-1:0]            ema_r, ema_nxt;
  logic [PTR_W-1:0]                      pos_r, pos_nxt;
  logic [FILL_W-1:0]                     fill_r, fill_nxt;
  logic [SUM_W-1:0]                      sum_r, sum_nxt;
  logic                                  level_r, level_nxt;

  logic [SW-1:0]                         sample_r, sample_nxt;
  logic signed [lsfh_pkg::DIFF_W-1:0]    d_r, d_nxt;
  logic signed [lsfh_pkg::PROD_W-1:0]    acc_r, acc_nxt, acc_sh;
  logic [STEP_W-1:0]                     step_r, step_nxt;
  logic [SUM_W-1:0]                      div_r, div_nxt;
  logic [FILL_W-1:0]                     rem_r, rem_nxt;

  logic                                  out_valid_r, out_valid_nxt;
  logic [lsfh_pkg::OUT_TDATA_W-1:0]      out_data_r, out_data_nxt;

  logic [SW-1:0]                         ring_mem [WINDOW_MAX];
  logic [SW-1:0]                         rd_data_r;
  logic                                  ring_rd, ring_wr;

  lsfh_pkg::alpha_stat_t                 alpha_stat;
  logic                                  alpha_start;
  logic                                  cfg_clear;

  logic                                  in_acc;
  logic [lsfh_pkg::EMA_W-1:0]            s_q15;
  logic [8:0]                            w9;
  logic [FILL_W-1:0]                     w_lim;
  logic                                  ring_full;
  logic [PTR_W:0]                        pos_inc;
  logic [SUM_W-1:0]                      sum_upd;
  logic [FILL_W:0]                       rem_sh;
  logic                                  q_bit;
  logic [SW-1:0]                         filt;
  logic [SW:0]                           off_sum;
  logic [SW-1:0]                         off_pt;
  logic                                  lvl_new;

  assign in_tready  = (state_r == ST_IDLE) && !init_r && !alpha_stat.busy;
  assign in_acc     = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  lsfh_alpha_div u_alpha (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (alpha_start),
    .permille (perm_nxt),
    .stat     (alpha_stat)
  );

  always_comb begin
    s_q15 = {in_tdata[SW-1:0], lsfh_pkg::Q15_SHIFT'(0)};

    // window clamp 1..WINDOW_MAX
    if (win_r == '0) begin
      w9 = 9'd1;
    end else if ({1'b0, win_r} > 9'(WINDOW_MAX)) begin
      w9 = 9'(WINDOW_MAX);
    end else begin
      w9 = {1'b0, win_r};
    end
    w_lim = FILL_W'(w9);

    ring_full = (fill_r >= w_lim);
    pos_inc   = {1'b0, pos_r} + 1'b1;
    sum_upd   = sum_r - (ring_full ? SUM_W'(rd_data_r) : SUM_W'(0)) + SUM_W'(sample_r);

    rem_sh = {rem_r, div_r[SUM_W-1]};
    q_bit  = (rem_sh >= {1'b0, fill_r});

    acc_sh = acc_r >>> lsfh_pkg::Q15_SHIFT;

    filt = mode_r ? div_r[SW-1:0] : ema_r[lsfh_pkg::EMA_W-1:lsfh_pkg::Q15_SHIFT];

    off_sum = {1'b0, thr_r} + {1'b0, hyst_r};
    off_pt  = off_sum[SW] ? lsfh_pkg::SAMPLE_MAX_INT[SW-1:0] : off_sum[SW-1:0];
    // low-active: on at or below threshold, off at or above off point
    lvl_new = level_r ? (filt < off_pt) : (filt <= thr_r);

    state_nxt     = state_r;
    mode_nxt      = mode_r;
    thr_nxt       = thr_r;
    hyst_nxt      = hyst_r;
    perm_nxt      = perm_r;
    win_nxt       = win_r;
    ema_nxt       = ema_r;
    pos_nxt       = pos_r;
    fill_nxt      = fill_r;
    sum_nxt       = sum_r;
    level_nxt     = level_r;
    sample_nxt    = sample_r;
    d_nxt         = d_r;
    acc_nxt       = acc_r;
    step_nxt      = step_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    ring_rd       = 1'b0;
    ring_wr       = 1'b0;
    cfg_clear     = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          sample_nxt = in_tdata[SW-1:0];
          if (mode_r) begin
            ring_rd   = 1'b1;
            state_nxt = ST_SMA_RD;
          end else if (ema_r == '0) begin
            // empty accumulator reloads from the sample
            ema_nxt   = s_q15;
            state_nxt = ST_DONE;
          end else begin
            d_nxt     = $signed({1'b0, s_q15}) - $signed({1'b0, ema_r});
            acc_nxt   = '0;
            step_nxt  = STEP_W'(lsfh_pkg::ALPHA_W - 1);
            state_nxt = ST_EMA_MUL;
          end
        end
      end
      ST_EMA_MUL: begin
        // alpha * d, one alpha bit per cycle, MSB first
        acc_nxt = (acc_r <<< 1) +
                  (alpha_stat.alpha[step_r[lsfh_pkg::ALPHA_IDX_W-1:0]]
                     ? {{(lsfh_pkg::PROD_W - lsfh_pkg::DIFF_W){d_r[lsfh_pkg::DIFF_W-1]}}, d_r}
                     : lsfh_pkg::PROD_W'(0));
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_EMA_UPD;
        end
      end
      ST_EMA_UPD: begin
        ema_nxt   = ema_r + acc_sh[lsfh_pkg::EMA_W-1:0];
        state_nxt = ST_DONE;
      end
      ST_SMA_RD: begin
        ring_wr  = 1'b1;
        fill_nxt = ring_full ? fill_r : fill_r + 1'b1;
        sum_nxt  = sum_upd;
        pos_nxt  = (pos_inc >= (PTR_W + 1)'(w_lim)) ? PTR_W'(0) : pos_inc[PTR_W-1:0];
        div_nxt  = sum_upd;
        rem_nxt  = '0;
        step_nxt = STEP_W'(SUM_W - 1);
        state_nxt = ST_SMA_DIV;
      end
      ST_SMA_DIV: begin
        // restoring divide by the fill count, one quotient bit per cycle
        rem_nxt  = q_bit ? FILL_W'(rem_sh - {1'b0, fill_r}) : rem_sh[FILL_W-1:0];
        div_nxt  = {div_r[SUM_W-2:0], q_bit};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt[SW-1:0]    = sample_r;
          out_data_nxt[2*SW-1:SW] = filt;
          out_data_nxt[lsfh_pkg::OUT_LEVEL_BIT] = lvl_new;
          out_data_nxt[lsfh_pkg::OUT_RISE_BIT]  = !level_r && lvl_new;
          out_data_nxt[lsfh_pkg::OUT_FALL_BIT]  = level_r && !lvl_new;
          out_data_nxt[lsfh_pkg::OUT_SAT_BIT]   = (sample_r <= lsfh_pkg::SAT_LOW) ||
                                                  (sample_r >= lsfh_pkg::SAT_HIGH);
          level_nxt = lvl_new;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (cfg_valid) begin
      unique case (cfg_addr)
        lsfh_pkg::CFG_FILTER_MODE: begin
          mode_nxt  = cfg_data[0];
          cfg_clear = 1'b1;
        end
        lsfh_pkg::CFG_ON_THRESHOLD: begin
          thr_nxt   = cfg_data[SW-1:0];
          cfg_clear = 1'b1;
        end
        lsfh_pkg::CFG_HYSTERESIS: begin
          hyst_nxt  = cfg_data[SW-1:0];
          cfg_clear = 1'b1;
        end
        lsfh_pkg::CFG_EMA_PERMILLE: begin
          perm_nxt  = cfg_data[lsfh_pkg::PERMILLE_W-1:0];
          cfg_clear = 1'b1;
        end
        lsfh_pkg::CFG_WINDOW: begin
          win_nxt   = cfg_data[lsfh_pkg::WIN_SET_W-1:0];
          cfg_clear = 1'b1;
        end
        default: begin
          cfg_clear = 1'b0;
        end
      endcase
    end

    if (cfg_clear) begin
      ema_nxt   = '0;
      pos_nxt   = '0;
      fill_nxt  = '0;
      sum_nxt   = '0;
      level_nxt = 1'b0;
    end

    alpha_start = cfg_clear || init_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      init_r      <= 1'b1;
      mode_r      <= 1'b0;
      thr_r       <= lsfh_pkg::RST_ON_THRESHOLD;
      hyst_r      <= lsfh_pkg::RST_HYSTERESIS;
      perm_r      <= lsfh_pkg::RST_EMA_PERMILLE;
      win_r       <= lsfh_pkg::RST_WINDOW;
      ema_r       <= '0;
      pos_r       <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      level_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= 1'b0;
      mode_r      <= mode_nxt;
      thr_r       <= thr_nxt;
      hyst_r      <= hyst_nxt;
      perm_r      <= perm_nxt;
      win_r       <= win_nxt;
      ema_r       <= ema_nxt;
      pos_r       <= pos_nxt;
      fill_r      <= fill_nxt;
      sum_r       <= sum_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sample_r   <= sample_nxt;
    d_r        <= d_nxt;
    acc_r      <= acc_nxt;
    step_r     <= step_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  // sample ring: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (ring_wr) begin
      ring_mem[pos_r] <= sample_r;
    end
    if (ring_rd) begin
      rd_data_r <= ring_mem[pos_r];
    end
  end

endmodule

### design/lsfh_alpha_div.sv
`timescale 1ns / 1ps

// Serial restoring divide of (clamped permille << 12) by 125, one quotient bit
// per cycle. Result is the Q15 blend weight.
module lsfh_alpha_div (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  input  logic [lsfh_pkg::PERMILLE_W-1:0]      permille,
  output lsfh_pkg::alpha_stat_t                stat
);

  logic                                  busy_r, busy_nxt;
  logic [lsfh_pkg::ALPHA_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [lsfh_pkg::ALPHA_DIVD_W-1:0]     div_r, div_nxt;
  logic [lsfh_pkg::ALPHA_REM_W-1:0]      rem_r, rem_nxt;
  logic [lsfh_pkg::PERMILLE_W-1:0]       k_clamp;
  logic [lsfh_pkg::ALPHA_REM_W:0]        rem_sh;
  logic                                  q_bit;

  always_comb begin
    if (permille == '0) begin
      k_clamp = lsfh_pkg::PERMILLE_W'(1);
    end else if (permille > lsfh_pkg::PERMILLE_FULL) begin
      k_clamp = lsfh_pkg::PERMILLE_FULL;
    end else begin
      k_clamp = permille;
    end

    rem_sh = {rem_r, div_r[lsfh_pkg::ALPHA_DIVD_W-1]};
    q_bit  = (rem_sh >= lsfh_pkg::ALPHA_DIVISOR);

    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;

    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = lsfh_pkg::ALPHA_CNT_W'(lsfh_pkg::ALPHA_DIVD_W - 1);
      div_nxt  = {k_clamp, lsfh_pkg::ALPHA_SCALE_SHIFT'(0)};
      rem_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = q_bit ? lsfh_pkg::ALPHA_REM_W'(rem_sh - lsfh_pkg::ALPHA_DIVISOR)
                      : rem_sh[lsfh_pkg::ALPHA_REM_W-1:0];
      div_nxt = {div_r[lsfh_pkg::ALPHA_DIVD_W-2:0], q_bit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    cnt_r <= cnt_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  // quotient never exceeds 32768, fits the low 16 bits
  assign stat.busy  = busy_r;
  assign stat.alpha = div_r[lsfh_pkg::ALPHA_W-1:0];

endmodule

### design/lsfh_checker.sv
`timescale 1ns / 1ps
`include "light_sensor_filter_hysteresis_defines.svh"

module lsfh_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [lsfh_pkg::OUT_TDATA_W-1:0]  out_tdata
);

  logic [lsfh_pkg::SAMPLE_W-1:0] raw;
  logic                          lvl, rise, fall, sat;

  assign raw  = out_tdata[lsfh_pkg::SAMPLE_W-1:0];
  assign lvl  = out_tdata[lsfh_pkg::OUT_LEVEL_BIT];
  assign rise = out_tdata[lsfh_pkg::OUT_RISE_BIT];
  assign fall = out_tdata[lsfh_pkg::OUT_FALL_BIT];
  assign sat  = out_tdata[lsfh_pkg::OUT_SAT_BIT];

  `LSFH_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `LSFH_ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  // an edge flag must agree with the level it reports
  `LSFH_ASSERT_NOW(a_edge_level, clk, rst_n, out_tvalid, (!rise || lvl) && (!fall || !lvl))
  `LSFH_ASSERT_NOW(a_sat_flag, clk, rst_n, out_tvalid, sat == ((raw <= lsfh_pkg::SAT_LOW) || (raw >= lsfh_pkg::SAT_HIGH)))

endmodule

bind light_sensor_filter_hysteresis lsfh_checker u_lsfh_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### dv/tb_light_sensor_filter_hysteresis.sv
`timescale 1ns / 1ps

module tb_light_sensor_filter_hysteresis;
  import lsfh_pkg::*;

  localparam int WINDOW_MAX   = 64;
  localparam int REG_COUNT    = 5;     // indexes at or above this are ignored by the block
  localparam int STALL_LIMIT  = 3000;
  localparam int LONG_HOLD    = 400;
  localparam int TAIL_CYCLES  = 40;
  localparam int RANDOM_ITEMS = 1500;
  localparam logic [63:0] Q15_ONE      = 64'd32768;
  localparam int unsigned PERMILLE_TOP = 1000;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] filt;
    logic                level;
    logic                rise;
    logic                fall;
    logic                sat;
  } light_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [11:0] sample
  logic                   out_tvalid;
  logic                   out_tready;
  // [11:0] raw_out, [23:12] filtered_out, [24] level, [25] rising_edge,
  // [26] falling_edge, [27] saturated
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0]  cfg_data;

  light_sensor_filter_hysteresis i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor copy of registers and filter state
  logic                  cur_mode;
  logic [SAMPLE_W-1:0]   cur_threshold;
  logic [SAMPLE_W-1:0]   cur_hysteresis;
  logic [PERMILLE_W-1:0] cur_permille;
  logic [WIN_SET_W-1:0]  cur_window;
  logic [63:0]           ema_acc;
  logic [SAMPLE_W-1:0]   sma_ring [WINDOW_MAX];
  int                    sma_pos;
  int                    sma_fill;
  int                    sma_sum;
  logic                  level_now;

  light_result_t pending_results [$];
  light_result_t monitor_want;

  int unsigned err_count = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cfg_writes = 0;
  int unsigned rises_seen = 0;
  int unsigned falls_seen = 0;
  int          idle_cycles = 0;
  int          hold_cycles = 0;
  int          burst_left = 0;
  int          rx_left = 0;
  int          rx_style = 0;

  function automatic void clear_filter_state();
    ema_acc   = '0;
    sma_pos   = 0;
    sma_fill  = 0;
    sma_sum   = 0;
    level_now = 1'b0;
    foreach (sma_ring[i]) sma_ring[i] = '0;
  endfunction

  function automatic void reset_predictor();
    cur_mode       = 1'b0;
    cur_threshold  = RST_ON_THRESHOLD;
    cur_hysteresis = RST_HYSTERESIS;
    cur_permille   = RST_EMA_PERMILLE;
    cur_window     = RST_WINDOW;
    clear_filter_state();
  endfunction

  function automatic void apply_register(logic [CFG_ADDR_W-1:0] addr,
                                         logic [CFG_DATA_W-1:0] data);
    case (addr)
      CFG_FILTER_MODE:  cur_mode       = data[0];
      CFG_ON_THRESHOLD: cur_threshold  = data[SAMPLE_W-1:0];
      CFG_HYSTERESIS:   cur_hysteresis = data[SAMPLE_W-1:0];
      CFG_EMA_PERMILLE: cur_permille   = data[PERMILLE_W-1:0];
      CFG_WINDOW:       cur_window     = data[WIN_SET_W-1:0];
      default:          return;
    endcase
    clear_filter_state();
  endfunction

  function automatic logic [SAMPLE_W-1:0] ema_update(logic [SAMPLE_W-1:0] s);
    logic [63:0] k;
    logic [63:0] alpha;
    k = (cur_permille == 0) ? 64'd1 :
        (cur_permille > PERMILLE_TOP) ? 64'(PERMILLE_TOP) : 64'(cur_permille);
    alpha = (k * Q15_ONE) / 64'(PERMILLE_TOP);
    // an empty accumulator takes the sample as is
    if (ema_acc == 0)
      ema_acc = 64'(s) << Q15_SHIFT;
    else
      ema_acc = ((Q15_ONE - alpha) * ema_acc + alpha * (64'(s) << Q15_SHIFT)) >> Q15_SHIFT;
    return ema_acc[Q15_SHIFT +: SAMPLE_W];
  endfunction

  function automatic logic [SAMPLE_W-1:0] sma_update(logic [SAMPLE_W-1:0] s);
    int w;
    w = (cur_window == 0) ? 1 : (cur_window > WINDOW_MAX) ? WINDOW_MAX : int'(cur_window);
    if (sma_fill < w)
      sma_fill++;
    else
      sma_sum -= sma_ring[sma_pos];
    sma_ring[sma_pos] = s;
    sma_sum += s;
    sma_pos++;
    if (sma_pos >= w) sma_pos = 0;
    return SAMPLE_W'(sma_sum / sma_fill);
  endfunction

  function automatic light_result_t predict_light_result(logic [SAMPLE_W-1:0] s);
    light_result_t r;
    logic [SAMPLE_W:0] off;
    logic prev;
    r.raw  = s;
    r.filt = cur_mode ? sma_update(s) : ema_update(s);
    off = cur_threshold + cur_hysteresis;
    if (off > SAMPLE_MAX_INT) off = SAMPLE_MAX_INT;
    prev = level_now;
    if (!prev && r.filt <= cur_threshold) level_now = 1'b1;
    if (prev && r.filt >= off) level_now = 1'b0;
    r.level = level_now;
    r.rise  = !prev && level_now;
    r.fall  = prev && !level_now;
    r.sat   = (s <= SAT_LOW) || (s >= SAT_HIGH);
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int unsigned got,
                               input int unsigned want);
    $display("ERROR %0t ns result %0d %s: got %0d, expected %0d",
             $time, results_seen, what, got, want);
    err_count++;
  endtask

  // sender: bursts of random length, random gaps between them
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_tvalid = 1'b1;
    in_tdata  = IN_TDATA_W'(s);
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(predict_light_result(s));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_tvalid  = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(input logic [CFG_ADDR_W-1:0] addr,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_addr  = addr;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    apply_register(addr, data);
    cfg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic int unsigned pick_value(int unsigned top, int unsigned typical);
    case ($urandom_range(0, 7))
      0:       return 0;
      1:       return top;
      2:       return typical;
      3:       return 1;
      4, 5:    return $urandom_range(0, typical);
      default: return $urandom_range(0, top);
    endcase
  endfunction

  task automatic randomize_settings();
    logic [4:0] picks;
    logic [CFG_DATA_W-1:0] noise;
    picks = 5'($urandom_range(1, 31));
    noise = CFG_DATA_W'($urandom);
    if (picks[0]) write_register(CFG_FILTER_MODE, noise);
    if (picks[1]) write_register(CFG_ON_THRESHOLD, CFG_DATA_W'(pick_value(4095, 4095)));
    if (picks[2]) write_register(CFG_HYSTERESIS, CFG_DATA_W'(pick_value(4095, 300)));
    // upper data bits beyond each register's width must be dropped
    if (picks[3])
      write_register(CFG_EMA_PERMILLE, {noise[11:10], 10'(pick_value(1023, 1000))});
    if (picks[4])
      write_register(CFG_WINDOW, {noise[11:8], 8'(pick_value(255, 16))});
    if ($urandom_range(0, 7) == 0)
      write_register(CFG_ADDR_W'(REG_COUNT + $urandom_range(0, 2)), CFG_DATA_W'($urandom));
  endtask

  // receiver: own ready pattern, plus a counted long hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready  = 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      if (rx_left == 0) begin
        rx_style = $urandom_range(0, 3);
        rx_left  = $urandom_range(1, 60);
      end
      rx_left = rx_left - 1;
      case (rx_style)
        0, 1:    out_tready = 1'b1;
        2:       out_tready = 1'($urandom_range(0, 1));
        default: out_tready = ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        flag_mismatch("item with nothing expected", out_tdata, 0);
      end else begin
        monitor_want = pending_results.pop_front();
        if (out_tdata[11:0] !== monitor_want.raw)
          flag_mismatch("raw_out", out_tdata[11:0], monitor_want.raw);
        if (out_tdata[23:12] !== monitor_want.filt)
          flag_mismatch("filtered_out", out_tdata[23:12], monitor_want.filt);
        if (out_tdata[OUT_LEVEL_BIT] !== monitor_want.level)
          flag_mismatch("level", out_tdata[OUT_LEVEL_BIT], monitor_want.level);
        if (out_tdata[OUT_RISE_BIT] !== monitor_want.rise)
          flag_mismatch("rising_edge", out_tdata[OUT_RISE_BIT], monitor_want.rise);
        if (out_tdata[OUT_FALL_BIT] !== monitor_want.fall)
          flag_mismatch("falling_edge", out_tdata[OUT_FALL_BIT], monitor_want.fall);
        if (out_tdata[OUT_SAT_BIT] !== monitor_want.sat)
          flag_mismatch("saturated", out_tdata[OUT_SAT_BIT], monitor_want.sat);
      end
      if (out_tdata[OUT_RISE_BIT] === 1'b1) rises_seen++;
      if (out_tdata[OUT_FALL_BIT] === 1'b1) falls_seen++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // reset settings, exponential mode; zero samples keep reloading an empty accumulator
  task automatic test_default_settings();
    send_sample(12'd0);
    send_sample(12'd0);
    send_sample(12'd4095);
    send_sample(12'd4095);
    send_sample(12'd5);
    send_sample(12'd6);
    send_sample(12'd4089);
    send_sample(12'd4090);
    send_sample(12'd1000);
    send_sample(12'd3800);
  endtask

  // writes past the register list must leave the filter state alone
  task automatic test_unused_index();
    drain_results();
    write_register(CFG_ADDR_W'(REG_COUNT), 12'hFFF);
    write_register(CFG_ADDR_W'(REG_COUNT + 2), 12'h000);
    send_sample(12'd2048);
    send_sample(12'd17);
  endtask

  task automatic test_ema_weight_limits();
    drain_results();
    write_register(CFG_EMA_PERMILLE, 12'd0);      // acts as 1
    send_sample(12'd4095);
    send_sample(12'd0);
    drain_results();
    write_register(CFG_EMA_PERMILLE, 12'd1000);
    send_sample(12'd100);
    send_sample(12'd3000);
    drain_results();
    write_register(CFG_EMA_PERMILLE, 12'hFFF);    // 1023 after masking, acts as 1000
    send_sample(12'd4095);
    send_sample(12'd0);
  endtask

  task automatic test_window_limits();
    drain_results();
    write_register(CFG_FILTER_MODE, 12'd1);
    write_register(CFG_WINDOW, 12'd0);            // acts as 1
    send_sample(12'd4095);
    send_sample(12'd1);
    send_sample(12'd2222);
    drain_results();
    write_register(CFG_WINDOW, 12'd255);          // capped at 64
    send_sample(12'd4095);
    send_sample(12'd0);
    send_sample(12'd4095);
  endtask

  task automatic test_threshold_limits();
    drain_results();
    write_register(CFG_ON_THRESHOLD, 12'd0);
    write_register(CFG_HYSTERESIS, 12'd0);
    send_sample(12'd0);
    send_sample(12'd1);
    drain_results();
    // off point saturates at full scale
    write_register(CFG_ON_THRESHOLD, 12'd4095);
    write_register(CFG_HYSTERESIS, 12'd4095);
    send_sample(12'd4095);
    send_sample(12'd4094);
  endtask

  // receiver holds off while the sender keeps offering, so the input backs up
  task automatic test_output_stall();
    int n;
    drain_results();
    hold_cycles = LONG_HOLD;
    for (n = 0; n < 12; n++) send_sample(SAMPLE_W'($urandom));
  endtask

  // phases of random settings; runs of samples park on either side of the
  // comparator points so the level keeps switching
  task automatic test_random_phases(input int unsigned target_items);
    int unsigned phase_len;
    int unsigned run_len;
    int unsigned lo;
    int unsigned hi;
    int unsigned c;
    int unsigned off;
    while (items_sent < target_items) begin
      drain_results();
      randomize_settings();
      phase_len = $urandom_range(40, 140);
      while (phase_len > 0) begin
        off = cur_threshold + cur_hysteresis;
        if (off > SAMPLE_MAX_INT) off = SAMPLE_MAX_INT;
        case ($urandom_range(0, 5))
          0, 1: begin lo = 0;   hi = cur_threshold;  end
          2, 3: begin lo = off; hi = SAMPLE_MAX_INT; end
          4:    begin lo = 0;   hi = SAMPLE_MAX_INT; end
          default: begin
            if ($urandom_range(0, 1)) begin
              lo = 0;
              hi = SAT_LOW;
            end else begin
              lo = SAT_HIGH;
              hi = SAMPLE_MAX_INT;
            end
          end
        endcase
        c  = $urandom_range(lo, hi);
        lo = (c > 40) ? c - 40 : 0;
        hi = (c + 40 > SAMPLE_MAX_INT) ? SAMPLE_MAX_INT : c + 40;
        run_len = $urandom_range(1, 30);
        while (run_len > 0 && phase_len > 0) begin
          if ($urandom_range(0, 9) == 0)
            send_sample(SAMPLE_W'($urandom));
          else
            send_sample(SAMPLE_W'($urandom_range(lo, hi)));
          run_len--;
          phase_len--;
        end
      end
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_addr   = '0;
    cfg_data   = '0;
    reset_predictor();
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_default_settings();
    test_unused_index();
    test_ema_weight_limits();
    test_window_limits();
    test_threshold_limits();
    test_output_stall();
    test_random_phases(items_sent + RANDOM_ITEMS);

    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0)
      flag_mismatch("items never delivered", pending_results.size(), 0);
    $display("Ran %0d samples through both filter modes with %0d register writes;",
             items_sent, cfg_writes);
    $display("checked %0d results, level rose %0d and fell %0d times, %0d errors",
             results_seen, rises_seen, falls_seen, err_count);
    if (err_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/lsfh_pkg.sv
design/lsfh_alpha_div.sv
design/light_sensor_filter_hysteresis.sv
design/lsfh_checker.sv
dv/tb_light_sensor_filter_hysteresis.sv
